FILE: hw/rtl/mlr_pkg.sv
package mlr_pkg;

  // Breakpoint table geometry.
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = AddrW + 1;

  // Q16.16 datapath widths.
  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 2 * DataW;

  // Opcodes of an input request.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Largest quotient that can still matter before the final saturation.
  localparam logic [DataW+1:0] QuotSat = {2'b10, {DataW{1'b0}}};

  typedef enum logic [3:0] {
    StIdle,
    StWalkRd,
    StWalkChk,
    StLoRd,
    StPrep,
    StMul,
    StDiv,
    StDivWait,
    StFin,
    StOut
  } state_e;

endpackage

FILE: hw/rtl/mlr_divider.sv
module mlr_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mlr_pkg::ProdW-1:0]       dividend_i,
  input  logic [mlr_pkg::DataW-1:0]       divisor_i,
  output logic                            done_o,
  output logic [mlr_pkg::ProdW-1:0]       quotient_o
);

  localparam int unsigned CntW = $clog2(mlr_pkg::ProdW);

  logic                         busy_q;
  logic                         done_q;
  logic [CntW-1:0]              cnt_q;
  logic [mlr_pkg::ProdW-1:0]    quo_q;
  logic [mlr_pkg::DataW-1:0]    rem_q;
  logic [mlr_pkg::DataW-1:0]    div_q;
  logic [mlr_pkg::DataW:0]      rem_sh;
  logic [mlr_pkg::DataW:0]      rem_sub;
  logic                         qbit;

  // One restoring step per cycle, one quotient bit at a time.
  assign rem_sh  = {rem_q, quo_q[mlr_pkg::ProdW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign qbit    = (rem_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(mlr_pkg::ProdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[mlr_pkg::ProdW-2:0], qbit};
      rem_q <= qbit ? rem_sub[mlr_pkg::DataW-1:0] : rem_sh[mlr_pkg::DataW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/monotonic_linear_resampler.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  opcode_i, first_of_run_i, x_value_i, y_value_i
// out       output     out_valid_o/out_ready_i interp_value_o, table_empty_o
//
// A load request leaves the block ready for the next request. A query on a table of
// fewer than two entries goes straight to the output. Otherwise a query walks the
// bracket, then interpolates through the bit-serial divider, or, when it is clamped,
// takes an end value, or the lower y when the bracket has equal x.
// Reset clears the entry count and bracket pointer; the tables need no clearing pass.
// One request is in flight at a time; a finished result waits in the output register
// while the next request is taken, and a stalled output holds the next result back.
module monotonic_linear_resampler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic                          first_of_run_i,
  input  logic signed [31:0]            x_value_i,
  input  logic signed [31:0]            y_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            interp_value_o,
  output logic                          table_empty_o
);

  localparam int unsigned AW = mlr_pkg::AddrW;
  localparam int unsigned CW = mlr_pkg::CountW;
  localparam int unsigned DW = mlr_pkg::DataW;

  // Breakpoint memories: one write port, one registered read port each.
  logic [DW-1:0] mem_x [mlr_pkg::TableDepth];
  logic [DW-1:0] mem_y [mlr_pkg::TableDepth];

  mlr_pkg::state_e state_q, state_d;

  logic [CW-1:0]        entry_count_q;
  logic [AW-1:0]        bracket_q;
  logic [AW-1:0]        lo_q;
  logic signed [DW-1:0] xv_q;
  logic signed [DW-1:0] x_first_q, y_first_q, x_last_q, y_last_q;
  logic                 asc_q, clamp_lo_q, clamp_hi_q;
  logic signed [DW-1:0] x1_q, y1_q, y0_q;
  logic signed [DW-1:0] rd_x_q, rd_y_q;
  logic [AW-1:0]        rd_addr;
  logic [DW-1:0]        mag_dy_q, mag_dt_q, mag_dx_q;
  logic                 neg_q;
  logic [2*DW-1:0]      prod_q;
  logic signed [DW-1:0] res_q;
  logic                 empty_q;
  logic                 out_valid_q;
  logic signed [DW-1:0] out_value_q;
  logic                 out_empty_q;

  logic                 accept;
  logic                 div_start, div_done;
  logic [2*DW-1:0]      div_quot;
  logic                 out_load;

  assign accept = in_valid_i && in_ready_o;

  // Differences of the bracket, formed when the lower entry arrives from memory.
  logic signed [DW:0]   dx, dt, dy;
  logic                 walk_more;
  logic [CW-1:0]        lo_plus2;
  logic                 asc_now, clamp_lo_now, clamp_hi_now;
  logic [CW-1:0]        n_minus2;

  assign dx = {x1_q[DW-1], x1_q} - {rd_x_q[DW-1], rd_x_q};
  assign dt = {xv_q[DW-1], xv_q} - {rd_x_q[DW-1], rd_x_q};
  assign dy = {y1_q[DW-1], y1_q} - {rd_y_q[DW-1], rd_y_q};

  function automatic logic [DW-1:0] mag33(input logic signed [DW:0] v);
    logic [DW:0] a;
    a = v[DW] ? (~v + 1'b1) : v;
    return a[DW-1:0];
  endfunction

  assign lo_plus2  = {1'b0, lo_q} + CW'(2);
  assign walk_more = (lo_plus2 < entry_count_q) &&
                     (asc_q ? (rd_x_q < xv_q) : (rd_x_q > xv_q));

  assign n_minus2     = entry_count_q - CW'(2);
  assign asc_now      = x_first_q < x_last_q;
  assign clamp_lo_now = asc_now ? (x_value_i <= x_first_q) : (x_value_i >= x_first_q);
  assign clamp_hi_now = asc_now ? (x_value_i >= x_last_q) : (x_value_i <= x_last_q);

  // Final sum: the quotient is capped at 2^33 before it meets y0, then the sum saturates.
  logic [DW+1:0]        q_sat;
  logic signed [DW+3:0] sum;
  logic signed [DW-1:0] sum_sat;

  assign q_sat = (div_quot > {{(DW-2){1'b0}}, mlr_pkg::QuotSat}) ? mlr_pkg::QuotSat
                                                                 : div_quot[DW+1:0];
  assign sum   = neg_q ? ({{4{y0_q[DW-1]}}, y0_q} - {2'b00, q_sat})
                       : ({{4{y0_q[DW-1]}}, y0_q} + {2'b00, q_sat});
  always_comb begin
    if (!sum[DW+3] && (sum[DW+2:DW-1] != '0)) begin
      sum_sat = {1'b0, {(DW-1){1'b1}}};
    end else if (sum[DW+3] && (sum[DW+2:DW-1] != '1)) begin
      sum_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sum_sat = sum[DW-1:0];
    end
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    rd_addr    = lo_q;
    unique case (state_q)
      mlr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (accept && opcode_i == mlr_pkg::OpQuery) begin
          if (entry_count_q < CW'(2)) begin
            state_d = mlr_pkg::StOut;
          end else begin
            state_d = mlr_pkg::StWalkRd;
          end
        end
      end
      mlr_pkg::StWalkRd: begin
        rd_addr = lo_q + AW'(1);
        state_d = mlr_pkg::StWalkChk;
      end
      mlr_pkg::StWalkChk: begin
        state_d = walk_more ? mlr_pkg::StWalkRd : mlr_pkg::StLoRd;
      end
      mlr_pkg::StLoRd: begin
        state_d = mlr_pkg::StPrep;
      end
      mlr_pkg::StPrep: begin
        if (clamp_lo_q || clamp_hi_q || dx == '0) begin
          state_d = mlr_pkg::StOut;
        end else begin
          state_d = mlr_pkg::StMul;
        end
      end
      mlr_pkg::StMul: begin
        state_d = mlr_pkg::StDiv;
      end
      mlr_pkg::StDiv: begin
        div_start = 1'b1;
        state_d   = mlr_pkg::StDivWait;
      end
      mlr_pkg::StDivWait: begin
        if (div_done) begin
          state_d = mlr_pkg::StFin;
        end
      end
      mlr_pkg::StFin: begin
        state_d = mlr_pkg::StOut;
      end
      mlr_pkg::StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = mlr_pkg::StIdle;
        end
      end
      default: begin
        state_d = mlr_pkg::StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mlr_pkg::StIdle;
      entry_count_q <= '0;
      bracket_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (opcode_i == mlr_pkg::OpLoad) begin
          if (first_of_run_i) begin
            entry_count_q <= CW'(1);
            bracket_q     <= '0;
          end else if (entry_count_q < CW'(mlr_pkg::TableDepth)) begin
            entry_count_q <= entry_count_q + CW'(1);
          end
        end else if (first_of_run_i) begin
          bracket_q <= '0;
        end
      end
      if (state_q == mlr_pkg::StWalkChk && !walk_more) begin
        bracket_q <= lo_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table memories: write on load, registered read every cycle.
  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == mlr_pkg::OpLoad) begin
      if (first_of_run_i) begin
        mem_x[0] <= x_value_i;
        mem_y[0] <= y_value_i;
      end else if (entry_count_q < CW'(mlr_pkg::TableDepth)) begin
        mem_x[entry_count_q[AW-1:0]] <= x_value_i;
        mem_y[entry_count_q[AW-1:0]] <= y_value_i;
      end
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (opcode_i == mlr_pkg::OpLoad) begin
        // The end points are kept beside the memory so that clamping needs no read.
        if (first_of_run_i || entry_count_q == '0) begin
          x_first_q <= x_value_i;
          y_first_q <= y_value_i;
          x_last_q  <= x_value_i;
          y_last_q  <= y_value_i;
        end else if (entry_count_q < CW'(mlr_pkg::TableDepth)) begin
          x_last_q <= x_value_i;
          y_last_q <= y_value_i;
        end
      end else begin
        xv_q       <= x_value_i;
        asc_q      <= asc_now;
        clamp_lo_q <= clamp_lo_now;
        clamp_hi_q <= clamp_hi_now;
        empty_q    <= (entry_count_q == '0);
        res_q      <= (entry_count_q == '0) ? '0 : y_first_q;
        if (first_of_run_i) begin
          lo_q <= '0;
        end else if ({1'b0, bracket_q} > n_minus2) begin
          lo_q <= n_minus2[AW-1:0];
        end else begin
          lo_q <= bracket_q;
        end
      end
    end
    if (state_q == mlr_pkg::StWalkChk) begin
      if (walk_more) begin
        lo_q <= lo_q + AW'(1);
      end else begin
        x1_q <= rd_x_q;
        y1_q <= rd_y_q;
      end
    end
    if (state_q == mlr_pkg::StPrep) begin
      y0_q     <= rd_y_q;
      mag_dx_q <= mag33(dx);
      mag_dt_q <= mag33(dt);
      mag_dy_q <= mag33(dy);
      neg_q    <= (dy != '0) && (dt != '0) && ((dy[DW] ^ dt[DW]) ^ dx[DW]);
      if (clamp_lo_q) begin
        res_q <= y_first_q;
      end else if (clamp_hi_q) begin
        res_q <= y_last_q;
      end else begin
        res_q <= rd_y_q;
      end
    end
    if (state_q == mlr_pkg::StMul) begin
      prod_q <= mag_dy_q * mag_dt_q;
    end
    if (state_q == mlr_pkg::StFin) begin
      res_q <= sum_sat;
    end
    if (out_load) begin
      out_value_q <= res_q;
      out_empty_q <= empty_q;
    end
  end

  mlr_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (mag_dx_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_value_q;
  assign table_empty_o  = out_empty_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CW'(mlr_pkg::TableDepth))
    else $error("entry count beyond table depth");

  a_done_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == mlr_pkg::StDivWait)
    else $error("divider finished outside its wait state");

  a_empty_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_empty_o |-> interp_value_o == '0)
    else $error("empty table answered a non-zero value");

  a_bracket_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mlr_pkg::StWalkChk |-> lo_q + AW'(1) < entry_count_q)
    else $error("bracket walk read beyond the loaded entries");
`endif

endmodule
